// ===== hw/rtl/cst_pkg.sv =====
// Package for the configuration script tokenizer.
// Holds the token and queue entry types, lexer mode codes and character constants.
// No dependencies.
package cst_pkg;

  localparam int LINE_BITS = 16;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam int OUT_USED_W = 8 + 1 + LINE_BITS;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_WORD    = 2'd2;

  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_NL   = 2'd1;
  localparam logic [1:0] KIND_LBR  = 2'd2;
  localparam logic [1:0] KIND_RBR  = 2'd3;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           ch;
    logic                 word_end;
    logic [LINE_BITS-1:0] line;
    logic                 last;
  } token_t;

  // One queue entry carries every token caused by one input transaction.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } group_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_status_t;

endpackage

// ===== hw/rtl/cst_front.sv =====
// Front end of the tokenizer: accepts bytes, runs the lexer state and
// builds a group of up to two tokens per transaction. Depends on cst_pkg.
module cst_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            byte_value,
  input  cst_pkg::queue_status_t q_status,
  output logic                  push,
  output cst_pkg::group_t       push_group
);

  logic [1:0]                    lex_mode, lex_mode_next;
  logic [7:0]                    held_char, held_char_next;
  logic                          held_is_first, held_is_first_next;
  logic [cst_pkg::LINE_BITS-1:0] line_count, line_count_next;
  logic                          prev_was_cr, prev_was_cr_next;
  logic                          newline_suppress, newline_suppress_next;

  logic            accept;
  logic [1:0]      n;
  cst_pkg::token_t t0, t1, end_tok, last_tok;
  logic            is_nl, is_ws, is_brace, count_line;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign is_nl    = (byte_value == cst_pkg::CH_CR) || (byte_value == cst_pkg::CH_LF);
  assign is_ws    = (byte_value == cst_pkg::CH_SPACE) || (byte_value == cst_pkg::CH_TAB) ||
                    (byte_value == cst_pkg::CH_CR);
  assign is_brace = (byte_value == cst_pkg::CH_LBRACE) || (byte_value == cst_pkg::CH_RBRACE);
  assign count_line = (byte_value == cst_pkg::CH_CR) ||
                      ((byte_value == cst_pkg::CH_LF) && !prev_was_cr);

  // Token that closes the pending word; a lone brace becomes a bracket.
  always_comb begin
    end_tok.ch       = held_char;
    end_tok.line     = line_count;
    end_tok.last     = 1'b0;
    end_tok.kind     = cst_pkg::KIND_WORD;
    end_tok.word_end = 1'b1;
    if (held_is_first && (held_char == cst_pkg::CH_LBRACE)) begin
      end_tok.kind     = cst_pkg::KIND_LBR;
      end_tok.word_end = 1'b0;
    end else if (held_is_first && (held_char == cst_pkg::CH_RBRACE)) begin
      end_tok.kind     = cst_pkg::KIND_RBR;
      end_tok.word_end = 1'b0;
    end
  end

  always_comb begin
    n                  = 2'd0;
    t0                 = end_tok;
    t1                 = end_tok;
    t1.kind            = cst_pkg::KIND_NL;
    t1.ch              = byte_value;
    t1.word_end        = 1'b0;
    lex_mode_next      = lex_mode;
    held_char_next     = held_char;
    held_is_first_next = held_is_first;

    unique case (lex_mode)
      cst_pkg::MODE_COMMENT: begin
        if (is_nl) begin
          lex_mode_next = cst_pkg::MODE_READY;
        end
      end
      cst_pkg::MODE_WORD: begin
        if (is_nl) begin
          n             = 2'd2;
          lex_mode_next = cst_pkg::MODE_READY;
        end else if (is_ws) begin
          n             = 2'd1;
          lex_mode_next = cst_pkg::MODE_READY;
        end else if (is_brace) begin
          n       = 2'd2;
          t1.kind = (byte_value == cst_pkg::CH_LBRACE) ? cst_pkg::KIND_LBR : cst_pkg::KIND_RBR;
          lex_mode_next = cst_pkg::MODE_READY;
        end else if (byte_value == cst_pkg::CH_HASH) begin
          n             = 2'd1;
          lex_mode_next = cst_pkg::MODE_COMMENT;
        end else begin
          // The word goes on: release the held character without an end mark.
          n                  = 2'd1;
          t0.kind            = cst_pkg::KIND_WORD;
          t0.word_end        = 1'b0;
          held_char_next     = byte_value;
          held_is_first_next = 1'b0;
        end
      end
      default: begin
        if (byte_value == cst_pkg::CH_HASH) begin
          lex_mode_next = cst_pkg::MODE_COMMENT;
        end else if (is_nl) begin
          if (!newline_suppress) begin
            n           = 2'd1;
            t0          = t1;
          end
          lex_mode_next = cst_pkg::MODE_READY;
        end else if (!is_ws) begin
          held_char_next     = byte_value;
          held_is_first_next = 1'b1;
          lex_mode_next      = cst_pkg::MODE_WORD;
        end else begin
          lex_mode_next = cst_pkg::MODE_READY;
        end
      end
    endcase

    line_count_next = line_count;
    if (count_line && (line_count != cst_pkg::LINE_MAX)) begin
      line_count_next = line_count + 1'b1;
    end
    prev_was_cr_next = (byte_value == cst_pkg::CH_CR);

    // End of stream flushes a pending word and restarts as after reset.
    if (action) begin
      n                  = (lex_mode == cst_pkg::MODE_WORD) ? 2'd1 : 2'd0;
      t0                 = end_tok;
      lex_mode_next      = cst_pkg::MODE_READY;
      held_char_next     = 8'h00;
      held_is_first_next = 1'b0;
      line_count_next    = {{(cst_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      prev_was_cr_next   = 1'b0;
    end

    last_tok = (n == 2'd2) ? t1 : t0;
    if (action) begin
      newline_suppress_next = 1'b1;
    end else if (n != 2'd0) begin
      newline_suppress_next = (last_tok.kind == cst_pkg::KIND_NL);
    end else begin
      newline_suppress_next = newline_suppress;
    end

    t0.last = (n != 2'd2);
    t1.last = 1'b1;
  end

  assign push            = accept && (n != 2'd0);
  assign push_group.tok0 = t0;
  assign push_group.tok1 = t1;
  assign push_group.two  = (n == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= cst_pkg::MODE_READY;
      held_char        <= 8'h00;
      held_is_first    <= 1'b0;
      line_count       <= {{(cst_pkg::LINE_BITS-1){1'b0}}, 1'b1};
      prev_was_cr      <= 1'b0;
      newline_suppress <= 1'b1;
    end else if (accept) begin
      lex_mode         <= lex_mode_next;
      held_char        <= held_char_next;
      held_is_first    <= held_is_first_next;
      line_count       <= line_count_next;
      prev_was_cr      <= prev_was_cr_next;
      newline_suppress <= newline_suppress_next;
    end
  end

endmodule

// ===== hw/rtl/cst_queue.sv =====
// Short queue of token groups between the lexer front end and the output side.
// Depends on cst_pkg.
module cst_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cst_pkg::group_t        push_group,
  input  logic                   pop,
  output cst_pkg::group_t        head,
  output cst_pkg::queue_status_t status
);

  cst_pkg::group_t              mem [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [cst_pkg::QUEUE_AW:0]   count;

  assign head            = mem[rd_ptr];
  assign status.full     = (count == cst_pkg::QUEUE_AW'(0) + (cst_pkg::QUEUE_AW+1)'(cst_pkg::QUEUE_DEPTH));
  assign status.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.nonempty)
    else $error("queue pop while empty");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count != '0))
    else $error("queue count lost a push");

endmodule

// ===== hw/rtl/cst_back.sv =====
// Output side of the tokenizer: sends tokens of queue groups one per cycle
// when not stalled, through a registered stream port. Depends on cst_pkg.
module cst_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cst_pkg::group_t        head,
  input  cst_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cst_pkg::token_t        out_token
);

  logic sel;
  logic load;

  assign load = !out_valid || out_ready;
  assign pop  = load && q_status.nonempty && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (load && q_status.nonempty) begin
      out_token <= sel ? head.tok1 : head.tok0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= 1'b0;
    end else if (load) begin
      out_valid <= q_status.nonempty;
      if (q_status.nonempty) begin
        sel <= !pop;
      end
    end
  end

endmodule

// ===== hw/rtl/config_script_tokenizer_top.sv =====
// Top level of the configuration script tokenizer.
// Joins the lexer front end, the group queue and the output side; depends on cst_pkg.
//
// Usage:
//   Input stream s_axis: one transaction per script byte (s_axis_tuser = 0) or an
//   end-of-stream flush (s_axis_tuser = 1, data ignored). Output stream m_axis:
//   one transaction per token; m_axis_tlast marks the last token caused by one
//   input transaction. An input that causes no token produces nothing.
//   The accepting edge writes the group of an accepted byte into the queue; the
//   output register is then loaded from the queue head once it is free, so the
//   queue and the output register lie between input and output.
//   Bytes are accepted one per cycle while the queue is not full. The output
//   side moves one token per cycle out of the queue while the receiver is ready,
//   so a byte that causes two tokens holds its group at the head until both go.
//   Reset clears the lexer to its start state (line 1, no pending word, leading
//   newlines dropped) and empties the queue.
//   When the receiver stalls, the output register holds its token and the queue
//   of four groups fills; s_axis_tready then goes low until space frees up.
module config_script_tokenizer_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] byte_value
  input  logic                           s_axis_tuser,  // [0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] char_value, [8] word_end, [24:9] line_number
  output logic [cst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] token_kind
  output logic                           m_axis_tlast   // last
);

  logic                   push, pop;
  cst_pkg::group_t        push_group, head;
  cst_pkg::queue_status_t q_status;
  cst_pkg::token_t        out_token;

  cst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .action     (s_axis_tuser),
    .byte_value (s_axis_tdata),
    .q_status   (q_status),
    .push       (push),
    .push_group (push_group)
  );

  cst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  cst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_token (out_token)
  );

  assign m_axis_tdata = {{(cst_pkg::OUT_DATA_W-cst_pkg::OUT_USED_W){1'b0}},
                         out_token.line, out_token.word_end, out_token.ch};
  assign m_axis_tuser = out_token.kind;
  assign m_axis_tlast = out_token.last;

endmodule
